@@ rtl/modular_exponentiation_unit_macros.svh @@
// Assertion macros shared by the modular exponentiation unit.
`ifndef MODULAR_EXPONENTIATION_UNIT_MACROS_SVH
`define MODULAR_EXPONENTIATION_UNIT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define MEU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define MEU_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ rtl/meu_pkg.sv @@
// Types and constants shared by the modular exponentiation unit.
package meu_pkg;

  // Sequencer states of the exponentiation loop.
  typedef enum logic [2:0] {
    StIdle,
    StReduce,
    StSquare,
    StMult,
    StOut
  } state_e;

  // Status reported by the shared modular multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mm_status_t;

  localparam int unsigned CfgIdxWidth = 1;

  localparam logic [CfgIdxWidth-1:0] CfgModulus  = 1'b0;
  localparam logic [CfgIdxWidth-1:0] CfgExponent = 1'b1;

endpackage

@@ rtl/meu_if.sv @@
// Request channels of the modular exponentiation unit: base in, result out.
interface meu_base_if #(
  parameter int unsigned WIDTH = 20
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] base;

  modport source (output valid, output base, input ready);
  modport sink   (input valid, input base, output ready);
endinterface

interface meu_result_if #(
  parameter int unsigned WIDTH = 20
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

@@ rtl/meu_modmul.sv @@
// Bit-serial interleaved modular multiplier: x * y mod m, one multiplier bit a cycle.
`include "modular_exponentiation_unit_macros.svh"

module meu_modmul #(
  parameter int unsigned W = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [W-1:0]        x_i,
  input  logic [W-1:0]        y_i,
  input  logic [W-1:0]        m_i,
  output meu_pkg::mm_status_t status_o,
  output logic [W-1:0]        prod_o
);

  localparam int unsigned CntW = $clog2(W);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    acc_q, acc_d;
  logic [W-1:0]    x_q, x_d;
  logic [W-1:0]    y_q, y_d;
  logic [W-1:0]    m_q, m_d;

  logic [W:0] dbl, dbl_red, sum, sum_red;

  // The multiplicand must already be below the modulus, so that each of the two
  // steps needs at most one subtraction.
  always_comb begin
    dbl     = {acc_q, 1'b0};
    dbl_red = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
    sum     = dbl_red + (y_q[W-1] ? {1'b0, x_q} : '0);
    sum_red = (sum >= {1'b0, m_q}) ? sum - {1'b0, m_q} : sum;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    m_d    = m_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(W - 1);
      acc_d  = '0;
      x_d    = x_i;
      y_d    = y_i;
      m_d    = m_i;
    end else if (busy_q) begin
      acc_d = sum_red[W-1:0];
      y_d   = {y_q[W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    m_q   <= m_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign prod_o        = acc_q;

  `MEU_ASSERT(a_acc_below_mod, busy_q |-> (acc_q < m_q), "partial product not reduced")
  `MEU_ASSERT(a_done_ends_run, done_q |-> (!busy_q && $past(busy_q)), "done without a run")
  `MEU_ASSERT_NEVER(a_no_restart, start_i && busy_q, "multiplier started while busy")

endmodule

@@ rtl/modular_exponentiation_unit.sv @@
// Modular exponentiation unit: result = base ^ exponent mod modulus, by
// square-and-multiply over the exponent bits from the most significant down, with
// every modular product formed by one shared bit-serial multiplier. A request
// first reduces the base (one product), then spends one squaring per exponent bit
// and one more product per set bit; an exponent of zero or a modulus of zero
// skips the products and goes straight to the output. The unit takes one request
// at a time and is ready again as soon as the result sits in the output register.
// Modulus and exponent must be written through the configuration port only while
// the unit is idle; the unit itself does not enforce this.
`include "modular_exponentiation_unit_macros.svh"

module modular_exponentiation_unit #(
  parameter int unsigned OPERAND_WIDTH = 20
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [meu_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [OPERAND_WIDTH-1:0]         cfg_data_i,
  meu_base_if.sink                         base_i,
  meu_result_if.source                     result_o
);

  localparam int unsigned W    = OPERAND_WIDTH;
  localparam int unsigned BitW = $clog2(W);

  meu_pkg::state_e state_q, state_d;

  logic [W-1:0]    modulus_q, modulus_d;
  logic [W-1:0]    exponent_q, exponent_d;
  logic [W-1:0]    base_q, base_d;
  logic [W-1:0]    bred_q, bred_d;
  logic [W-1:0]    acc_q, acc_d;
  logic [BitW-1:0] bit_q, bit_d;
  logic            issued_q, issued_d;
  logic            out_valid_q, out_valid_d;
  logic [W-1:0]    out_q, out_d;

  logic                in_fire;
  logic                load_out;
  logic                mm_start;
  logic [W-1:0]        mm_x, mm_y, mm_prod;
  meu_pkg::mm_status_t mm_stat;
  logic                last_bit;
  logic                exp_bit;

  assign in_fire  = base_i.valid && base_i.ready;
  assign load_out = (state_q == meu_pkg::StOut) && (!out_valid_q || result_o.ready);
  assign last_bit = (bit_q == '0);
  assign exp_bit  = exponent_q[bit_q];

  meu_modmul #(
    .W (W)
  ) u_modmul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mm_start),
    .x_i      (mm_x),
    .y_i      (mm_y),
    .m_i      (modulus_q),
    .status_o (mm_stat),
    .prod_o   (mm_prod)
  );

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      meu_pkg::StIdle: begin
        if (in_fire) begin
          if (exponent_q == '0 || modulus_q == '0) begin
            state_d = meu_pkg::StOut;
          end else begin
            state_d = meu_pkg::StReduce;
          end
        end
      end
      meu_pkg::StReduce: begin
        if (mm_stat.done) begin
          state_d = meu_pkg::StSquare;
        end
      end
      meu_pkg::StSquare: begin
        if (mm_stat.done) begin
          if (exp_bit) begin
            state_d = meu_pkg::StMult;
          end else if (last_bit) begin
            state_d = meu_pkg::StOut;
          end
        end
      end
      meu_pkg::StMult: begin
        if (mm_stat.done) begin
          state_d = last_bit ? meu_pkg::StOut : meu_pkg::StSquare;
        end
      end
      meu_pkg::StOut: begin
        if (load_out) begin
          state_d = meu_pkg::StIdle;
        end
      end
      default: state_d = meu_pkg::StIdle;
    endcase
  end

  // Datapath, multiplier control and configuration.
  always_comb begin
    modulus_d   = modulus_q;
    exponent_d  = exponent_q;
    base_d      = base_q;
    bred_d      = bred_q;
    acc_d       = acc_q;
    bit_d       = bit_q;
    issued_d    = issued_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !result_o.ready;
    mm_start    = 1'b0;
    mm_x        = acc_q;
    mm_y        = acc_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        meu_pkg::CfgModulus:  modulus_d  = cfg_data_i;
        meu_pkg::CfgExponent: exponent_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      meu_pkg::StIdle: begin
        if (in_fire) begin
          base_d = base_i.base;
          bit_d  = BitW'(W - 1);
          // A zero exponent gives one; a zero modulus gives zero otherwise.
          acc_d  = (exponent_q == '0) ? W'(1) :
                   (modulus_q == W'(1) || modulus_q == '0) ? '0 : W'(1);
        end
      end
      meu_pkg::StReduce: begin
        // base * 1 mod m brings the base below the modulus.
        mm_x = W'(1);
        mm_y = base_q;
        if (mm_stat.done) begin
          bred_d = mm_prod;
        end
      end
      meu_pkg::StSquare: begin
        if (mm_stat.done) begin
          acc_d = mm_prod;
          if (!exp_bit && !last_bit) begin
            bit_d = bit_q - 1'b1;
          end
        end
      end
      meu_pkg::StMult: begin
        mm_x = bred_q;
        mm_y = acc_q;
        if (mm_stat.done) begin
          acc_d = mm_prod;
          if (!last_bit) begin
            bit_d = bit_q - 1'b1;
          end
        end
      end
      meu_pkg::StOut: begin
        if (load_out) begin
          out_d       = acc_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase

    if (state_q == meu_pkg::StReduce || state_q == meu_pkg::StSquare ||
        state_q == meu_pkg::StMult) begin
      if (!issued_q) begin
        mm_start = 1'b1;
        issued_d = 1'b1;
      end else if (mm_stat.done) begin
        issued_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= meu_pkg::StIdle;
      modulus_q   <= W'(1);
      exponent_q  <= W'(1);
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      bit_q       <= '0;
    end else begin
      state_q     <= state_d;
      modulus_q   <= modulus_d;
      exponent_q  <= exponent_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
      bit_q       <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    bred_q <= bred_d;
    acc_q  <= acc_d;
    out_q  <= out_d;
  end

  assign base_i.ready    = (state_q == meu_pkg::StIdle);
  assign result_o.valid  = out_valid_q;
  assign result_o.result = out_q;

  `MEU_ASSERT(a_acc_reduced,
              (state_q == meu_pkg::StSquare || state_q == meu_pkg::StMult) |->
              (acc_q < modulus_q), "running value not below modulus")
  `MEU_ASSERT(a_out_from_seq, $rose(out_valid_q) |-> ($past(state_q) == meu_pkg::StOut),
              "result loaded outside the output state")
  `MEU_ASSERT(a_result_held, (result_o.valid && !result_o.ready) |=>
              (result_o.valid && $stable(result_o.result)), "waiting result not held")

endmodule
